FILE: rtl/rafc_pkg.sv
package rafc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_REPLY_HIT,
    ST_REPLY_MISS
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic insert;
    logic post;
    logic post_hit;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/rafc_ctrl.sv
module rafc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rafc_pkg::status_t status,
  output rafc_pkg::cmd_t    cmd
);

  rafc_pkg::state_t state_r;
  rafc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rafc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rafc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rafc_pkg::ST_SCAN;
        end
      end
      rafc_pkg::ST_SCAN: begin
        if (status.match) begin
          state_nxt = rafc_pkg::ST_REPLY_HIT;
        end else if (status.scan_end) begin
          state_nxt = rafc_pkg::ST_INSERT;
        end
      end
      rafc_pkg::ST_INSERT: begin
        state_nxt = rafc_pkg::ST_REPLY_MISS;
      end
      rafc_pkg::ST_REPLY_HIT, rafc_pkg::ST_REPLY_MISS: begin
        if (status.out_free) begin
          state_nxt = rafc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rafc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      rafc_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      rafc_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      rafc_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      rafc_pkg::ST_REPLY_HIT: begin
        cmd.post     = status.out_free;
        cmd.post_hit = 1'b1;
      end
      rafc_pkg::ST_REPLY_MISS: begin
        cmd.post = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_post_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> status.out_free)
    else $error("result posted while the output register is still full");

  a_insert_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> $past(state_r == rafc_pkg::ST_SCAN) && $past(status.scan_end))
    else $error("insert issued without a finished scan");

endmodule

FILE: rtl/rafc_datapath.sv
module rafc_datapath #(
  parameter int TABLE_DEPTH  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       in_instr_address,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_hit,
  input  rafc_pkg::cmd_t    cmd,
  output rafc_pkg::status_t status
);

  localparam int KEY_W = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] rd_data_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] fill_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_instr_address[KEY_W-1:0];
    end
    if (cmd.scan && (rd_idx_r != cnt_r)) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
    if (cmd.insert) begin
      mem[fill_r] <= key_r;
    end
    if (cmd.post) begin
      out_hit_r <= cmd.post_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        if (rd_idx_r != cnt_r) begin
          rd_idx_r  <= rd_idx_r + CNT_W'(1);
          cmp_vld_r <= 1'b1;
        end else begin
          cmp_vld_r <= 1'b0;
        end
      end
      if (cmd.insert) begin
        fill_r <= fill_r + IDX_W'(1);
        if (cnt_r != FULL_CNT) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.match    = cmp_vld_r && (rd_data_r == key_r);
  assign status.scan_end = !cmp_vld_r && (rd_idx_r == cnt_r);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("valid count above table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= cnt_r)
    else $error("scan index past the valid entries");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> fill_r == $past(fill_r) + IDX_W'(1))
    else $error("fill pointer did not advance on insert");

endmodule

FILE: rtl/recent_address_fifo_cache.sv
// Channel   Ports                                   Direction
// input     in_valid, in_ready, in_instr_address    into the block
// result    out_valid, out_ready, out_hit           out of the block
//
// A miss runs these steps in order: accept, one read of the table memory per
// valid entry, drain the last compare, see the scan end, insert and load the
// result register. With an empty table there are no reads and no compare to
// drain.
// A hit ends the walk at the matching entry.
// Reset clears the fill pointer, the valid count and all handshake state.
// A stalled result holds the block before it takes the next item.
module recent_address_fifo_cache #(
  parameter int TABLE_DEPTH  = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit
);

  rafc_pkg::cmd_t    cmd;
  rafc_pkg::status_t status;

  rafc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rafc_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_instr_address (in_instr_address),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
